### rtl/keyframe_piecewise_lerp_assert.svh
// ----------------------------------------------------------------------------
// keyframe_piecewise_lerp_assert.svh
// Assertion macros used by the interpolator top level.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_PIECEWISE_LERP_ASSERT_SVH
`define KEYFRAME_PIECEWISE_LERP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg
// Widths, codes and types shared by the keyframe interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package kpl_pkg;

  localparam int TICK_WIDTH  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int FACTOR_BITS = 16;
  localparam int VALUE_W     = 32;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int SPLIT_W     = TICK_WIDTH + 1;
  localparam int DEN_W       = TICK_WIDTH + 2;
  localparam int NUM_W       = TICK_WIDTH + FACTOR_BITS;
  localparam int STEP_BITS   = 4;
  localparam int DIV_STAGES  = (NUM_W + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W       = DIV_STAGES * STEP_BITS;
  localparam int DIFF_W      = VALUE_W + 1;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [1:0] {
    MODE_LINEAR    = 2'd0,
    MODE_ONE_KEY   = 2'd1,
    MODE_TWO_KEYS  = 2'd2,
    MODE_HOLD      = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_MODE    = 3'd0,
    REG_START_VALUE   = 3'd1,
    REG_END_VALUE     = 3'd2,
    REG_MID1_VALUE    = 3'd3,
    REG_MID1_FRACTION = 3'd4,
    REG_MID2_VALUE    = 3'd5,
    REG_MID2_FRACTION = 3'd6,
    REG_UNUSED        = 3'd7
  } cfg_idx_e;

  // Item handed to the divider; the side fields ride along unchanged.
  typedef struct packed {
    logic [TICK_WIDTH-1:0]    num;
    logic [DEN_W-1:0]         den_mag;
    logic                     den_neg;
    logic                     force_zero;
    logic                     zero_flag;
    logic signed [VALUE_W-1:0] from_val;
    logic signed [DIFF_W-1:0]  diff;
  } div_item_t;

endpackage
`default_nettype wire

### rtl/kpl_divider.sv
// ----------------------------------------------------------------------------
// kpl_divider
// Pipelined unsigned restoring divider, STEP_BITS (four) quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module kpl_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire kpl_pkg::div_item_t in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [kpl_pkg::DIV_W-1:0] out_quo_o,
  output kpl_pkg::div_item_t      out_item_o
);
  import kpl_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DIV_W-1:0] dvd;
    logic [DIV_W-1:0] quo;
  } div_work_t;

  logic      valid_q [DIV_STAGES];
  div_work_t work_q  [DIV_STAGES];
  div_item_t item_q  [DIV_STAGES];
  div_work_t work_d  [DIV_STAGES];
  logic      en      [DIV_STAGES];

  // Advance a stage when it is empty or the next one advances.
  always_comb begin
    en[DIV_STAGES-1] = !valid_q[DIV_STAGES-1] || !out_stall_i;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    div_work_t      w;
    logic [DEN_W-1:0] d;
    logic [DEN_W-1:0] r;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        w.rem = '0;
        w.dvd = DIV_W'(in_item_i.num) << FACTOR_BITS;
        w.quo = '0;
        d     = in_item_i.den_mag;
      end else begin
        w = work_q[k-1];
        d = item_q[k-1].den_mag;
      end
      for (int b = 0; b < STEP_BITS; b++) begin
        r     = {w.rem[DEN_W-2:0], w.dvd[DIV_W-1]};
        w.dvd = w.dvd << 1;
        if (r >= d) begin
          w.rem = r - d;
          w.quo = {w.quo[DIV_W-2:0], 1'b1};
        end else begin
          w.rem = r;
          w.quo = {w.quo[DIV_W-2:0], 1'b0};
        end
      end
      work_d[k] = w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) valid_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (en[k]) valid_q[k] <= (k == 0) ? in_valid_i : valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        work_q[k] <= work_d[k];
        item_q[k] <= (k == 0) ? in_item_i : item_q[k-1];
      end
    end
  end

  assign out_valid_o = valid_q[DIV_STAGES-1];
  assign out_quo_o   = work_q[DIV_STAGES-1].quo;
  assign out_item_o  = item_q[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/keyframe_piecewise_lerp.sv
// ----------------------------------------------------------------------------
// keyframe_piecewise_lerp
// Keyframe curve interpolator: position and duration in, Q16.16 value out.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken every cycle when nothing stalls. The
// divider has DIV_STAGES stages and resolves four quotient bits per stage;
// split multiply, segment select, factor clamp, the two product halves
// (together), the product sum and the final add/saturate take one stage each.
// A stall on the output only freezes stages that hold an item, so bubbles
// squeeze out.
// Write configuration only while the pipe is empty.
`default_nettype none
module keyframe_piecewise_lerp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [kpl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [kpl_pkg::VALUE_W-1:0]       cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [kpl_pkg::TICK_WIDTH-1:0]    position_i,
  input  wire logic [kpl_pkg::TICK_WIDTH-1:0]    duration_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [kpl_pkg::VALUE_W-1:0]     interp_value_o,
  output logic                                   zero_segment_o
);
  import kpl_pkg::*;

  `include "keyframe_piecewise_lerp_assert.svh"

  localparam int PLO_W  = VALUE_W + 17;
  localparam int PHI_W  = VALUE_W + DIFF_W - 16;
  localparam int PROD_W = VALUE_W + DIFF_W;
  localparam int QX_W   = DIV_W + VALUE_W;
  localparam logic [QX_W-1:0] T_POS_MAX = QX_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
  localparam logic [QX_W-1:0] T_NEG_MAG = QX_W'(64'd1 << (VALUE_W - 1));

  // Configuration registers.
  mode_e                     mode_q;
  logic signed [VALUE_W-1:0] start_q, end_q, mid1_q, mid2_q;
  logic [FRAC_W-1:0]         frac1_q, frac2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LINEAR;
      start_q <= '0;
      end_q   <= '0;
      mid1_q  <= '0;
      mid2_q  <= '0;
      frac1_q <= '0;
      frac2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_CURVE_MODE:    mode_q  <= mode_e'(cfg_wdata_i[1:0]);
        REG_START_VALUE:   start_q <= cfg_wdata_i;
        REG_END_VALUE:     end_q   <= cfg_wdata_i;
        REG_MID1_VALUE:    mid1_q  <= cfg_wdata_i;
        REG_MID1_FRACTION: frac1_q <= cfg_wdata_i[FRAC_W-1:0];
        REG_MID2_VALUE:    mid2_q  <= cfg_wdata_i;
        REG_MID2_FRACTION: frac2_q <= cfg_wdata_i[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids and enables.
  logic v_sp_q, v_sel_q, v_t_q, v_m_q, v_p_q, v_o_q;
  logic en_sp, en_sel, en_t, en_m, en_p, en_o;
  logic div_in_stall, div_out_valid;

  assign en_o   = !v_o_q   || !out_stall_i;
  assign en_p   = !v_p_q   || en_o;
  assign en_m   = !v_m_q   || en_p;
  assign en_t   = !v_t_q   || en_m;
  assign en_sel = !v_sel_q || !div_in_stall;
  assign en_sp  = !v_sp_q  || en_sel;
  assign in_stall_o = !en_sp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_sp_q  <= 1'b0;
      v_sel_q <= 1'b0;
      v_t_q   <= 1'b0;
      v_m_q   <= 1'b0;
      v_p_q   <= 1'b0;
      v_o_q   <= 1'b0;
    end else begin
      if (en_sp)  v_sp_q  <= in_valid_i;
      if (en_sel) v_sel_q <= v_sp_q;
      if (en_t)   v_t_q   <= div_out_valid;
      if (en_m)   v_m_q   <= v_t_q;
      if (en_p)   v_p_q   <= v_m_q;
      if (en_o)   v_o_q   <= v_p_q;
    end
  end

  // Split points: fraction times duration, drop the fraction bits.
  logic [TICK_WIDTH-1:0] pos_q, dur_q;
  logic [SPLIT_W-1:0]    s1_q, s2_q;
  logic [FRAC_W+TICK_WIDTH-1:0] sp1_prod, sp2_prod;

  assign sp1_prod = (FRAC_W+TICK_WIDTH)'(frac1_q) * (FRAC_W+TICK_WIDTH)'(duration_i);
  assign sp2_prod = (FRAC_W+TICK_WIDTH)'(frac2_q) * (FRAC_W+TICK_WIDTH)'(duration_i);

  always_ff @(posedge clk_i) begin
    if (en_sp) begin
      pos_q <= position_i;
      dur_q <= duration_i;
      s1_q  <= SPLIT_W'(sp1_prod >> FRAC_BITS);
      s2_q  <= SPLIT_W'(sp2_prod >> FRAC_BITS);
    end
  end

  // Segment select: pick the bounds and end values of the active segment.
  // A zero duration keeps the start value whatever the mode.
  div_item_t sel_d, sel_q;

  always_comb begin
    logic [SPLIT_W-1:0]      posx, durx, lo, hi;
    logic signed [DEN_W-1:0] den;
    logic signed [VALUE_W-1:0] to_val;
    logic                    active;
    posx   = SPLIT_W'(pos_q);
    durx   = SPLIT_W'(dur_q);
    lo     = '0;
    hi     = durx;
    active = (dur_q != '0);
    sel_d.from_val = start_q;
    to_val         = end_q;
    if (active) begin
      case (mode_q)
        MODE_LINEAR: ;
        MODE_ONE_KEY, MODE_TWO_KEYS: begin
          if (posx < s1_q) begin
            hi     = s1_q;
            to_val = mid1_q;
          end else if (mode_q == MODE_ONE_KEY) begin
            lo             = s1_q;
            sel_d.from_val = mid1_q;
          end else if (posx < s2_q) begin
            lo             = s1_q;
            hi             = s2_q;
            sel_d.from_val = mid1_q;
            to_val         = mid2_q;
          end else begin
            lo             = s2_q;
            sel_d.from_val = mid2_q;
          end
        end
        MODE_HOLD: active = 1'b0;
        default: active = 1'b0;
      endcase
    end
    den              = $signed(DEN_W'(hi)) - $signed(DEN_W'(lo));
    sel_d.num        = TICK_WIDTH'(posx - lo);
    sel_d.den_neg    = den[DEN_W-1];
    sel_d.den_mag    = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    sel_d.zero_flag  = active && (den == '0);
    sel_d.force_zero = !active || (den == '0);
    sel_d.diff       = DIFF_W'(to_val) - DIFF_W'(sel_d.from_val);
  end

  always_ff @(posedge clk_i) begin
    if (en_sel) sel_q <= sel_d;
  end

  // Factor division.
  logic [DIV_W-1:0] div_quo;
  div_item_t        div_item;

  kpl_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_sel_q),
    .in_stall_o  (div_in_stall),
    .in_item_i   (sel_q),
    .out_valid_o (div_out_valid),
    .out_stall_i (!en_t),
    .out_quo_o   (div_quo),
    .out_item_o  (div_item)
  );

  // Apply the sign of the divisor, force a zero factor when asked, and clamp the factor to 32 bits.
  logic signed [VALUE_W-1:0] t_d, t_q;
  logic signed [VALUE_W-1:0] t_from_q;
  logic signed [DIFF_W-1:0]  t_diff_q;
  logic                      t_zero_q, t_force_q;

  always_comb begin
    logic [QX_W-1:0] qx;
    qx = QX_W'(div_quo);
    if (div_item.force_zero) begin
      t_d = '0;
    end else if (!div_item.den_neg) begin
      t_d = (qx > T_POS_MAX) ? VALUE_W'(T_POS_MAX) : VALUE_W'(qx);
    end else begin
      t_d = (qx > T_NEG_MAG) ? VALUE_W'(T_NEG_MAG) : -VALUE_W'(qx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_t) begin
      t_q       <= t_d;
      t_from_q  <= div_item.from_val;
      t_diff_q  <= div_item.diff;
      t_zero_q  <= div_item.zero_flag;
      t_force_q <= div_item.force_zero;
    end
  end

  // Product halves: low sixteen bits of the span and the signed rest.
  logic signed [PLO_W-1:0]   plo_q;
  logic signed [PHI_W-1:0]   phi_q;
  logic signed [VALUE_W-1:0] m_from_q;
  logic                      m_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_m) begin
      plo_q    <= PLO_W'($signed(t_q)) * PLO_W'($signed({1'b0, t_diff_q[15:0]}));
      phi_q    <= PHI_W'($signed(t_q)) * PHI_W'($signed(t_diff_q[DIFF_W-1:16]));
      m_from_q <= t_from_q;
      m_zero_q <= t_zero_q;
    end
  end

  // Sum the halves.
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [VALUE_W-1:0] p_from_q;
  logic                      p_zero_q;

  always_ff @(posedge clk_i) begin
    if (en_p) begin
      prod_q   <= ($signed(PROD_W'(phi_q)) <<< 16) + $signed(PROD_W'(plo_q));
      p_from_q <= m_from_q;
      p_zero_q <= m_zero_q;
    end
  end

  // Scale back toward zero, add the segment start, saturate.
  logic signed [VALUE_W-1:0] out_d, out_q;
  logic                      out_zero_q;

  always_comb begin
    logic signed [PROD_W-1:0] biased, scaled, sum;
    biased = prod_q + (prod_q[PROD_W-1] ? PROD_W'((1 << FACTOR_BITS) - 1) : PROD_W'(0));
    scaled = biased >>> FACTOR_BITS;
    sum    = scaled + $signed(PROD_W'(p_from_q));
    if (sum > $signed(PROD_W'(T_POS_MAX))) begin
      out_d = VALUE_W'(T_POS_MAX);
    end else if (sum < -$signed(PROD_W'(T_NEG_MAG))) begin
      out_d = VALUE_W'(T_NEG_MAG);
    end else begin
      out_d = VALUE_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      out_q      <= out_d;
      out_zero_q <= p_zero_q;
    end
  end

  assign out_valid_o    = v_o_q;
  assign interp_value_o = out_q;
  assign zero_segment_o = out_zero_q;

  // Input backs up only when every stage is full and the output is held.
  `KPL_ASSERT_NOW(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i && v_p_q, "input stalled with room in pipe")
  // A zero-length segment always forces a zero factor.
  `KPL_ASSERT_NOW(a_zero_forces, clk_i, rst_ni, v_sel_q && sel_q.zero_flag, sel_q.force_zero, "zero segment without forced factor")
  // A forced factor reaches the multiplier as zero.
  `KPL_ASSERT_NOW(a_forced_t, clk_i, rst_ni, v_t_q && t_force_q, t_q == '0, "forced factor not zero")

endmodule
`default_nettype wire
